[design/mef_pkg.sv]
// Shared constants, register codes and types for the motor encoder feedback tracker.
// No dependencies; every other design file refers to it by scoped names.
package mef_pkg;

  // Field widths
  localparam int unsigned ANGLE_W     = 13;
  localparam int unsigned SPEED_W     = 16;
  localparam int unsigned TURN_W      = 24;
  localparam int unsigned ANGLE_OUT_W = 48;
  localparam int unsigned RATE_W      = 51;
  localparam int unsigned SCALE_W     = 24;
  localparam int unsigned GAIN_W      = 32;
  localparam int unsigned POS_W       = TURN_W + ANGLE_W + 1;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 32;

  // Default averaging window length
  localparam int unsigned WINDOW_LEN_DEFAULT = 8;

  // Register reset values
  localparam logic [ANGLE_W-1:0] WRAP_FWD_RST  = 13'd3000;
  localparam logic [ANGLE_W-1:0] WRAP_BACK_RST = 13'd3000;
  localparam logic [SCALE_W-1:0] TURN_SCALE_RST = 24'd92160;
  localparam logic [GAIN_W-1:0]  RATE_GAIN_RST  = 32'd65536;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WRAP_FWD  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WRAP_BACK = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TURN_SCALE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RATE_GAIN  = 2'd3;

  // Commands
  localparam logic CMD_SAMPLE  = 1'b0;
  localparam logic CMD_CAPTURE = 1'b1;

  // Wrap thresholds handed to the unwrap logic
  typedef struct packed {
    logic [ANGLE_W-1:0] fwd;
    logic [ANGLE_W-1:0] back;
  } thr_t;

  // Finished fields that ride alongside the divider chain
  typedef struct packed {
    logic [TURN_W-1:0]             turn;
    logic signed [ANGLE_OUT_W-1:0] angle;
    logic signed [SPEED_W-1:0]     speed;
    logic signed [SPEED_W-1:0]     current;
    logic                          neg;
  } side_t;

endpackage

[design/mef_unwrap.sv]
// Turn unwrap, zero capture and speed window of the feedback tracker.
// Depends on mef_pkg for widths, command codes and the threshold struct.
module mef_unwrap #(
  parameter int unsigned WINDOW_LEN = mef_pkg::WINDOW_LEN_DEFAULT,
  localparam int unsigned SUM_W = mef_pkg::SPEED_W + $clog2(WINDOW_LEN)
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    load_i,
  input  logic                                    command_i,
  input  logic [mef_pkg::ANGLE_W-1:0]             angle_i,
  input  logic signed [mef_pkg::SPEED_W-1:0]      speed_i,
  input  mef_pkg::thr_t                           thr_i,
  output logic [mef_pkg::TURN_W-1:0]              turn_o,
  output logic signed [mef_pkg::POS_W-1:0]        pos_sum_o,
  output logic signed [SUM_W-1:0]                 sum_o
);

  logic [mef_pkg::ANGLE_W-1:0]        zero_q, zero_d;
  logic [mef_pkg::ANGLE_W-1:0]        prev_q;
  logic [mef_pkg::TURN_W-1:0]         turn_q, turn_d;
  logic signed [mef_pkg::SPEED_W-1:0] win_q [WINDOW_LEN];
  logic signed [SUM_W-1:0]            sum_q, sum_d;
  logic                               sample;
  logic signed [mef_pkg::ANGLE_W:0]   diff;
  logic signed [mef_pkg::ANGLE_W:0]   offset;
  logic                               fwd_hit, back_hit;

  assign sample = (command_i == mef_pkg::CMD_SAMPLE);

  // Detect wrap jumps against the previous angle
  assign diff     = signed'({1'b0, angle_i}) - signed'({1'b0, prev_q});
  assign fwd_hit  = diff >= signed'({1'b0, thr_i.fwd});
  assign back_hit = diff <= -signed'({1'b0, thr_i.back});

  // Next turn count, zero angle and window sum
  always_comb begin
    turn_d = turn_q;
    zero_d = zero_q;
    sum_d  = sum_q;
    if (sample) begin
      turn_d = turn_q + mef_pkg::TURN_W'(back_hit) - mef_pkg::TURN_W'(fwd_hit);
      sum_d  = sum_q - SUM_W'(win_q[WINDOW_LEN-1]) + SUM_W'(speed_i);
    end else begin
      zero_d = angle_i;
    end
  end

  // Multi-turn position before scaling
  assign offset    = signed'({1'b0, angle_i}) - signed'({1'b0, zero_d});
  assign pos_sum_o = signed'({turn_d[mef_pkg::TURN_W-1], turn_d, {mef_pkg::ANGLE_W{1'b0}}})
                     + mef_pkg::POS_W'(offset);
  assign turn_o    = turn_d;
  assign sum_o     = sum_d;

  // Hold state; the window shifts one tap per sample, oldest at the tail
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zero_q <= '0;
      prev_q <= '0;
      turn_q <= '0;
      sum_q  <= '0;
      for (int i = 0; i < WINDOW_LEN; i++) begin
        win_q[i] <= '0;
      end
    end else if (load_i) begin
      zero_q <= zero_d;
      prev_q <= angle_i;
      turn_q <= turn_d;
      sum_q  <= sum_d;
      if (sample) begin
        win_q[0] <= speed_i;
        for (int i = 1; i < WINDOW_LEN; i++) begin
          win_q[i] <= win_q[i-1];
        end
      end
    end
  end

  // Turn count moves by at most one per item
  a_turn_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |=> (turn_q == $past(turn_q) || turn_q == $past(turn_q) + 24'd1 ||
                turn_q == $past(turn_q) - 24'd1))
    else $error("turn count jumped by more than one");

  // Capture leaves the window sum alone
  a_capture_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_i && !sample) |=> $stable(sum_q))
    else $error("capture changed the window sum");

  // Capture aligns previous angle with the new zero
  a_capture_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_i && !sample) |=> (prev_q == zero_q))
    else $error("capture did not align zero and previous angle");

endmodule

[design/mef_div_cell.sv]
// One radix-4 cell of the constant-divisor chain for the averaged rate.
// Depends on mef_pkg for the sideband struct; cells are chained in the top level.
module mef_div_cell #(
  parameter int unsigned WINDOW_LEN = mef_pkg::WINDOW_LEN_DEFAULT,
  parameter int unsigned DIV_W = 2,
  localparam int unsigned REM_W = $clog2(WINDOW_LEN)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic [REM_W-1:0]   rem_i,
  input  logic [DIV_W-1:0]   dvd_i,
  input  logic [DIV_W-1:0]   quo_i,
  input  mef_pkg::side_t     side_i,
  output logic               valid_o,
  output logic [REM_W-1:0]   rem_o,
  output logic [DIV_W-1:0]   dvd_o,
  output logic [DIV_W-1:0]   quo_o,
  output mef_pkg::side_t     side_o
);

  localparam logic [REM_W+1:0] DIV1 = (REM_W+2)'(WINDOW_LEN);
  localparam logic [REM_W+1:0] DIV2 = (REM_W+2)'(2 * WINDOW_LEN);
  localparam logic [REM_W+1:0] DIV3 = (REM_W+2)'(3 * WINDOW_LEN);

  logic [REM_W+1:0] part;
  logic [REM_W+1:0] part_left;
  logic [1:0]       digit;

  // Bring down two dividend bits and pick the quotient digit
  always_comb begin
    part = {rem_i, dvd_i[DIV_W-1 -: 2]};
    priority if (part >= DIV3) begin
      digit     = 2'd3;
      part_left = part - DIV3;
    end else if (part >= DIV2) begin
      digit     = 2'd2;
      part_left = part - DIV2;
    end else if (part >= DIV1) begin
      digit     = 2'd1;
      part_left = part - DIV1;
    end else begin
      digit     = 2'd0;
      part_left = part;
    end
  end

  // Valid travels with reset; the data words need none
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  // Advance remainder, dividend and quotient one digit
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_o  <= part_left[REM_W-1:0];
      dvd_o  <= {dvd_i[DIV_W-3:0], 2'b00};
      quo_o  <= {quo_i[DIV_W-3:0], digit};
      side_o <= side_i;
    end
  end

endmodule

[design/motor_encoder_feedback_tracker.sv]
// Motor encoder feedback tracker: unwrap, scaling pipeline and divider chain.
// Depends on mef_pkg, mef_unwrap and mef_div_cell.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) takes one feedback frame per item:
//   command, 13-bit rotor angle, speed and current. Command CMD_CAPTURE records
//   the zero angle; CMD_SAMPLE unwraps the angle and pushes the speed into the
//   averaging window. Every item gives exactly one result on the output channel
//   (out_valid_o / out_stall_i): turn count, scaled angle, averaged rate and the
//   echoed speed and current.
//   Throughput is one item per cycle while the receiver does not stall. The
//   pipeline has three stages of unwrap, partial products and sum, then one
//   radix-4 divider cell per two quotient bits.
//   When the receiver stalls the whole pipeline holds; one extra item is parked
//   in an input skid register, after which in_stall_o rises.
//   Reset clears the turn count, zero and previous angles, the window and the
//   pipeline; the registers return to their defaults. The config channel
//   (cfg_valid_i / cfg_ready_o) is always ready. The user must write it only
//   while idle; the block itself does not enforce this.
module motor_encoder_feedback_tracker #(
  parameter int unsigned WINDOW_LEN = mef_pkg::WINDOW_LEN_DEFAULT
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  // Input items
  input  logic                                     in_valid_i,
  output logic                                     in_stall_o,
  input  logic                                     command_i,
  input  logic [mef_pkg::ANGLE_W-1:0]              angle_raw_i,
  input  logic signed [mef_pkg::SPEED_W-1:0]       speed_word_i,
  input  logic signed [mef_pkg::SPEED_W-1:0]       current_word_i,
  // Result items
  output logic                                     out_valid_o,
  input  logic                                     out_stall_i,
  output logic signed [mef_pkg::TURN_W-1:0]        turn_total_o,
  output logic signed [mef_pkg::ANGLE_OUT_W-1:0]   angle_out_o,
  output logic signed [mef_pkg::RATE_W-1:0]        rate_out_o,
  output logic signed [mef_pkg::SPEED_W-1:0]       speed_echo_o,
  output logic signed [mef_pkg::SPEED_W-1:0]       current_echo_o,
  // Configuration writes
  input  logic                                     cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  logic [mef_pkg::CFG_IDX_W-1:0]            cfg_index_i,
  input  logic [mef_pkg::CFG_DATA_W-1:0]           cfg_data_i
);

  localparam int unsigned SUM_W  = mef_pkg::SPEED_W + $clog2(WINDOW_LEN);
  localparam int unsigned PROD_W = SUM_W + mef_pkg::GAIN_W + 1;
  localparam int unsigned MAG_W  = SUM_W + mef_pkg::GAIN_W - 1;
  localparam int unsigned NCELL  = (MAG_W + 1) / 2;
  localparam int unsigned DIV_W  = 2 * NCELL;
  localparam int unsigned REM_W  = $clog2(WINDOW_LEN);
  localparam int unsigned EXT_W  = (DIV_W + 1 > mef_pkg::RATE_W) ? DIV_W + 1 : mef_pkg::RATE_W;
  localparam int unsigned LO_W   = 19;
  localparam int unsigned HI_W   = mef_pkg::POS_W - LO_W;
  localparam int unsigned FULL_W = 63;

  // ---------------------------------------------------------------- config
  mef_pkg::thr_t                thr_q;
  logic [mef_pkg::SCALE_W-1:0]  scale_q;
  logic [mef_pkg::GAIN_W-1:0]   gain_q;

  assign cfg_ready_o = 1'b1;

  // Write registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q.fwd  <= mef_pkg::WRAP_FWD_RST;
      thr_q.back <= mef_pkg::WRAP_BACK_RST;
      scale_q    <= mef_pkg::TURN_SCALE_RST;
      gain_q     <= mef_pkg::RATE_GAIN_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        mef_pkg::REG_WRAP_FWD:   thr_q.fwd  <= cfg_data_i[mef_pkg::ANGLE_W-1:0];
        mef_pkg::REG_WRAP_BACK:  thr_q.back <= cfg_data_i[mef_pkg::ANGLE_W-1:0];
        mef_pkg::REG_TURN_SCALE: scale_q    <= cfg_data_i[mef_pkg::SCALE_W-1:0];
        mef_pkg::REG_RATE_GAIN:  gain_q     <= cfg_data_i[mef_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------------ input skid
  logic                               en;
  logic                               in_acc;
  logic                               skid_valid_q;
  logic                               skid_cmd_q;
  logic [mef_pkg::ANGLE_W-1:0]        skid_angle_q;
  logic signed [mef_pkg::SPEED_W-1:0] skid_speed_q;
  logic signed [mef_pkg::SPEED_W-1:0] skid_current_q;
  logic                               src_valid;
  logic                               src_cmd;
  logic [mef_pkg::ANGLE_W-1:0]        src_angle;
  logic signed [mef_pkg::SPEED_W-1:0] src_speed;
  logic signed [mef_pkg::SPEED_W-1:0] src_current;
  logic                               load;

  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = skid_valid_q;
  assign in_acc     = in_valid_i && !in_stall_o;

  // Take the parked item first
  assign src_valid   = skid_valid_q || in_valid_i;
  assign src_cmd     = skid_valid_q ? skid_cmd_q     : command_i;
  assign src_angle   = skid_valid_q ? skid_angle_q   : angle_raw_i;
  assign src_speed   = skid_valid_q ? skid_speed_q   : speed_word_i;
  assign src_current = skid_valid_q ? skid_current_q : current_word_i;
  assign load        = en && src_valid;

  // Park an item accepted while the pipeline holds
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_valid_q <= 1'b0;
    end else if (en) begin
      skid_valid_q <= 1'b0;
    end else if (in_acc) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!en && in_acc) begin
      skid_cmd_q     <= command_i;
      skid_angle_q   <= angle_raw_i;
      skid_speed_q   <= speed_word_i;
      skid_current_q <= current_word_i;
    end
  end

  // ---------------------------------------------------- stage 1: unwrap
  logic [mef_pkg::TURN_W-1:0]         uw_turn;
  logic signed [mef_pkg::POS_W-1:0]   uw_pos;
  logic signed [SUM_W-1:0]            uw_sum;

  mef_unwrap #(
    .WINDOW_LEN (WINDOW_LEN)
  ) u_unwrap (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (load),
    .command_i (src_cmd),
    .angle_i   (src_angle),
    .speed_i   (src_speed),
    .thr_i     (thr_q),
    .turn_o    (uw_turn),
    .pos_sum_o (uw_pos),
    .sum_o     (uw_sum)
  );

  logic                               s1_valid_q, s2_valid_q, s3_valid_q;
  logic [mef_pkg::TURN_W-1:0]         s1_turn_q, s2_turn_q;
  logic signed [mef_pkg::POS_W-1:0]   s1_pos_q;
  logic signed [SUM_W-1:0]            s1_sum_q;
  logic signed [mef_pkg::SPEED_W-1:0] s1_speed_q, s2_speed_q;
  logic signed [mef_pkg::SPEED_W-1:0] s1_current_q, s2_current_q;
  logic [LO_W+mef_pkg::SCALE_W-1:0]   s2_plo_q;
  logic signed [HI_W+mef_pkg::SCALE_W:0] s2_phi_q;
  logic signed [PROD_W-1:0]           s2_rprod_q;
  logic signed [FULL_W-1:0]           full;
  logic signed [PROD_W-1:0]           rabs;
  logic [MAG_W-1:0]                   s3_mag_q;
  mef_pkg::side_t                     s3_side_q;

  // Advance valid bits of the front stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q <= src_valid;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
    end
  end

  // Stage 2: partial products of the angle and the rate product
  // Stage 3: sum the partials, floor by 8192, take the rate magnitude
  assign full = (FULL_W'(s2_phi_q) <<< LO_W) + signed'(FULL_W'(s2_plo_q));
  assign rabs = s2_rprod_q[PROD_W-1] ? -s2_rprod_q : s2_rprod_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_turn_q    <= uw_turn;
      s1_pos_q     <= uw_pos;
      s1_sum_q     <= uw_sum;
      s1_speed_q   <= src_speed;
      s1_current_q <= src_current;

      s2_plo_q     <= s1_pos_q[LO_W-1:0] * scale_q;
      s2_phi_q     <= signed'(s1_pos_q[mef_pkg::POS_W-1:LO_W]) * signed'({1'b0, scale_q});
      s2_rprod_q   <= s1_sum_q * signed'({1'b0, gain_q});
      s2_turn_q    <= s1_turn_q;
      s2_speed_q   <= s1_speed_q;
      s2_current_q <= s1_current_q;

      s3_mag_q          <= rabs[MAG_W-1:0];
      s3_side_q.turn    <= s2_turn_q;
      s3_side_q.angle   <= full[mef_pkg::ANGLE_OUT_W+12:13];
      s3_side_q.speed   <= s2_speed_q;
      s3_side_q.current <= s2_current_q;
      s3_side_q.neg     <= s2_rprod_q[PROD_W-1];
    end
  end

  // --------------------------------------------------- divider cell chain
  logic             c_valid [NCELL+1];
  logic [REM_W-1:0] c_rem   [NCELL+1];
  logic [DIV_W-1:0] c_dvd   [NCELL+1];
  logic [DIV_W-1:0] c_quo   [NCELL+1];
  mef_pkg::side_t   c_side  [NCELL+1];

  assign c_valid[0] = s3_valid_q;
  assign c_rem[0]   = '0;
  assign c_dvd[0]   = DIV_W'(s3_mag_q);
  assign c_quo[0]   = '0;
  assign c_side[0]  = s3_side_q;

  for (genvar g = 0; g < NCELL; g++) begin : g_cell
    mef_div_cell #(
      .WINDOW_LEN (WINDOW_LEN),
      .DIV_W      (DIV_W)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (c_valid[g]),
      .rem_i   (c_rem[g]),
      .dvd_i   (c_dvd[g]),
      .quo_i   (c_quo[g]),
      .side_i  (c_side[g]),
      .valid_o (c_valid[g+1]),
      .rem_o   (c_rem[g+1]),
      .dvd_o   (c_dvd[g+1]),
      .quo_o   (c_quo[g+1]),
      .side_o  (c_side[g+1])
    );
  end

  // ---------------------------------------------------- output register
  logic signed [DIV_W:0] rate_pos;
  logic signed [DIV_W:0] rate_sgn;
  logic signed [EXT_W-1:0] rate_ext;
  mef_pkg::side_t        last_side;

  // Restore the sign of the truncated quotient
  assign last_side = c_side[NCELL];
  assign rate_pos  = signed'({1'b0, c_quo[NCELL]});
  assign rate_sgn  = last_side.neg ? -rate_pos : rate_pos;
  assign rate_ext  = EXT_W'(rate_sgn);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (en) begin
      out_valid_o <= c_valid[NCELL];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      turn_total_o   <= signed'(last_side.turn);
      angle_out_o    <= last_side.angle;
      rate_out_o     <= rate_ext[mef_pkg::RATE_W-1:0];
      speed_echo_o   <= last_side.speed;
      current_echo_o <= last_side.current;
    end
  end

  // The skid only fills in a cycle where the pipeline held
  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_valid_q) |-> $past(!en))
    else $error("skid filled while the pipeline advanced");

  // An item taken while the pipeline holds must be parked
  a_skid_park: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !en) |=> skid_valid_q)
    else $error("item accepted during hold was dropped");

  // Divider remainder stays below the window length
  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    c_valid[NCELL] |-> (32'(c_rem[NCELL]) < WINDOW_LEN))
    else $error("divider remainder out of range");

endmodule

[sim/testbench.sv]
// Self-checking bench for motor_encoder_feedback_tracker: directed frames, then random
// rotor motion under several register settings, with random idling on both channels.
// Depends on mef_pkg and the tracker RTL only.
module testbench;
  import mef_pkg::*;

  localparam int CYCLE        = 4;
  localparam int WIN          = WINDOW_LEN_DEFAULT;
  localparam int COUNTS_TURN  = 8192;
  // 3 front stages + output register, then one radix-4 cell per two quotient bits
  localparam int PIPE_LATENCY = 4 + (SPEED_W + $clog2(WIN) + 32) / 2;
  localparam int HOLD_CYCLES  = 120;

  typedef struct {
    logic [TURN_W-1:0]      turn;
    logic [ANGLE_OUT_W-1:0] angle;
    logic [RATE_W-1:0]      rate;
    logic [SPEED_W-1:0]     speed;
    logic [SPEED_W-1:0]     current;
  } feedback_t;

  // Predict tracker results and compare them against what comes out
  class rotor_scoreboard;
    logic [ANGLE_W-1:0]        fwd_thr;
    logic [ANGLE_W-1:0]        back_thr;
    logic [SCALE_W-1:0]        scale;
    logic [GAIN_W-1:0]         gain;
    logic [ANGLE_W-1:0]        zero_ang;
    logic [ANGLE_W-1:0]        prev_ang;
    logic signed [TURN_W-1:0]  turns;
    logic signed [SPEED_W-1:0] window [WIN];
    int                        wpos;
    int                        wsum;
    feedback_t                 pending_q[$];
    int unsigned errors, frames, results, captures, down_wraps, up_wraps, both_wraps;

    function new();
      fwd_thr  = WRAP_FWD_RST;
      back_thr = WRAP_BACK_RST;
      scale    = TURN_SCALE_RST;
      gain     = RATE_GAIN_RST;
      zero_ang = '0;
      prev_ang = '0;
      turns    = '0;
      foreach (window[i]) window[i] = '0;
      wpos = 0;
      wsum = 0;
      errors = 0; frames = 0; results = 0; captures = 0;
      down_wraps = 0; up_wraps = 0; both_wraps = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_WRAP_FWD:   fwd_thr = data[ANGLE_W-1:0];
        REG_WRAP_BACK:  back_thr = data[ANGLE_W-1:0];
        REG_TURN_SCALE: scale = data[SCALE_W-1:0];
        REG_RATE_GAIN:  gain = data[GAIN_W-1:0];
        default: ;
      endcase
    endfunction

    // Update the tracking state for one accepted frame and queue its result
    function void note_frame(logic cmd, logic [ANGLE_W-1:0] ang,
                             logic signed [SPEED_W-1:0] spd,
                             logic signed [SPEED_W-1:0] cur);
      int        diff;
      bit        down, up;
      longint    pos;
      feedback_t e;
      frames++;
      if (cmd == CMD_CAPTURE) begin
        zero_ang = ang;
        prev_ang = ang;
        captures++;
      end else begin
        diff = int'(ang) - int'(prev_ang);
        down = diff >= int'(fwd_thr);
        up   = diff <= -int'(back_thr);
        if (down) turns = turns - 1;
        if (up) turns = turns + 1;
        down_wraps += down;
        up_wraps   += up;
        both_wraps += down && up;
        // slide the speed window
        wsum = wsum - int'(window[wpos]) + int'(spd);
        window[wpos] = spd;
        wpos = (wpos + 1) % WIN;
        prev_ang = ang;
      end
      pos = longint'(ang) - longint'(zero_ang) + longint'(turns) * longint'(COUNTS_TURN);
      e.turn    = turns;
      e.angle   = ANGLE_OUT_W'((pos * longint'(scale)) >>> 13);
      e.rate    = RATE_W'((longint'(wsum) * longint'(gain)) / longint'(WIN));
      e.speed   = spd;
      e.current = cur;
      pending_q.push_back(e);
    endfunction

    function void field_check(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        errors++;
        if (errors <= 10)
          $display("mismatch in %s of result %0d: expected %h, got %h",
                   name, results, want, got);
      end
    endfunction

    function void check_result(logic [TURN_W-1:0] turn, logic [ANGLE_OUT_W-1:0] angle,
                               logic [RATE_W-1:0] rate, logic [SPEED_W-1:0] speed,
                               logic [SPEED_W-1:0] current);
      feedback_t e;
      results++;
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("result %0d arrived with nothing pending", results);
        return;
      end
      e = pending_q.pop_front();
      field_check("turn_total", 64'(e.turn), 64'(turn));
      field_check("angle_out", 64'(e.angle), 64'(angle));
      field_check("rate_out", 64'(e.rate), 64'(rate));
      field_check("speed_echo", 64'(e.speed), 64'(speed));
      field_check("current_echo", 64'(e.current), 64'(current));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic command = CMD_SAMPLE;
  logic [ANGLE_W-1:0] angle_raw = '0;
  logic signed [SPEED_W-1:0] speed_word = '0;
  logic signed [SPEED_W-1:0] current_word = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [TURN_W-1:0] turn_total;
  logic signed [ANGLE_OUT_W-1:0] angle_out;
  logic signed [RATE_W-1:0] rate_out;
  logic signed [SPEED_W-1:0] speed_echo;
  logic signed [SPEED_W-1:0] current_echo;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_WRAP_FWD;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  rotor_scoreboard sb;
  bit tx_quiet = 1'b0;
  bit rx_quiet = 1'b0;
  int unsigned hold_len = 0;
  int unsigned holds_done = 0;
  int unsigned settings = 0;
  logic [ANGLE_W-1:0] rotor_pos = '0;

  motor_encoder_feedback_tracker #(.WINDOW_LEN(WIN)) dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .command_i(command), .angle_raw_i(angle_raw),
    .speed_word_i(speed_word), .current_word_i(current_word),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .turn_total_o(turn_total), .angle_out_o(angle_out), .rate_out_o(rate_out),
    .speed_echo_o(speed_echo), .current_echo_o(current_echo),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  always #(CYCLE / 2) clk = ~clk;

  // Watch both handshakes
  always @(posedge clk) begin
    if (rst_n && in_valid && in_stall === 1'b0)
      sb.note_frame(command, angle_raw, speed_word, current_word);
    if (rst_n && out_valid === 1'b1 && !out_stall)
      sb.check_result(turn_total, angle_out, rate_out, speed_echo, current_echo);
  end

  // Offer one frame after a random gap and hold it until taken
  task automatic send_frame(input logic cmd, input logic [ANGLE_W-1:0] ang,
                            input logic [SPEED_W-1:0] spd, input logic [SPEED_W-1:0] cur);
    int unsigned gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    command      <= cmd;
    angle_raw    <= ang;
    speed_word   <= spd;
    current_word <= cur;
    do @(posedge clk); while (in_stall !== 1'b0);
  endtask

  // Write all four registers back to back; only called while idle
  task automatic program_regs(input logic [CFG_DATA_W-1:0] fwd, input logic [CFG_DATA_W-1:0] back,
                              input logic [CFG_DATA_W-1:0] scl, input logic [CFG_DATA_W-1:0] gn);
    logic [CFG_IDX_W-1:0]  idx [4];
    logic [CFG_DATA_W-1:0] val [4];
    idx = '{REG_WRAP_FWD, REG_WRAP_BACK, REG_TURN_SCALE, REG_RATE_GAIN};
    val = '{fwd, back, scl, gn};
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      do @(posedge clk); while (cfg_ready !== 1'b1);
      sb.set_reg(idx[i], val[i]);
    end
    cfg_valid <= 1'b0;
    settings++;
  endtask

  // Drop valid, then wait for every pending result plus the pipeline depth
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 4) @(posedge clk);
  endtask

  // Random rotor motion: runs at a steady velocity, some standstill,
  // occasional zero captures and stray frames
  task automatic run_motion(input int unsigned count);
    int unsigned left, run, r;
    int vel, spd;
    left = count;
    while (left != 0) begin
      run = $urandom_range(8, 40);
      vel = int'($urandom_range(0, 4000)) - 2000;
      for (int i = 0; i < run && left != 0; i++) begin
        r = $urandom_range(0, 99);
        spd = vel * 15 + int'($urandom_range(0, 2000)) - 1000;
        if ($urandom_range(0, 9) == 0) spd = int'($urandom);
        if (r < 5) begin
          send_frame(CMD_CAPTURE, rotor_pos, SPEED_W'(spd), SPEED_W'($urandom));
        end else if (r < 15) begin
          rotor_pos = ANGLE_W'($urandom);
          send_frame(CMD_SAMPLE, rotor_pos, SPEED_W'($urandom), SPEED_W'($urandom));
        end else if (r < 20) begin
          send_frame(CMD_SAMPLE, rotor_pos, SPEED_W'(spd), SPEED_W'($urandom));
        end else begin
          rotor_pos = ANGLE_W'(int'(rotor_pos) + vel + int'($urandom_range(0, 64)) - 32);
          send_frame(CMD_SAMPLE, rotor_pos, SPEED_W'(spd), SPEED_W'($urandom));
        end
        left--;
      end
    end
  endtask

  // Receiver: random stall before each result, and a long hold when asked
  initial begin
    int unsigned wait_n;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_len != 0) begin
        out_stall <= 1'b1;
        repeat (hold_len) @(posedge clk);
        hold_len = 0;
        holds_done++;
      end
      wait_n = rx_quiet ? 0 : $urandom_range(0, 6);
      if (wait_n != 0) begin
        out_stall <= 1'b1;
        repeat (wait_n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  // Guard against a hung handshake
  initial begin
    #(CYCLE * 200000);
    $display("testbench NOT OK");
    $finish;
  end

  initial begin
    logic [ANGLE_W-1:0] ang;
    sb = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed frames at reset settings: exact thresholds, field extremes, window limits
    program_regs(WRAP_FWD_RST, WRAP_BACK_RST, TURN_SCALE_RST, RATE_GAIN_RST);
    send_frame(CMD_CAPTURE, 13'd0, 16'sh0000, 16'sh0000);
    send_frame(CMD_SAMPLE, 13'd8191, 16'sh7FFF, 16'sh8000);
    send_frame(CMD_SAMPLE, 13'd0, 16'sh8000, 16'sh7FFF);
    send_frame(CMD_SAMPLE, 13'd100, 16'shFFFF, 16'shFFFF);
    send_frame(CMD_SAMPLE, 13'd3100, 16'sh0001, 16'sh0000);
    send_frame(CMD_SAMPLE, 13'd100, 16'sh0002, 16'sh0001);
    send_frame(CMD_SAMPLE, 13'd3099, 16'sh0003, 16'sh0002);
    send_frame(CMD_CAPTURE, 13'd8191, 16'sh7FFF, 16'sh8000);
    send_frame(CMD_SAMPLE, 13'd5191, 16'sh0004, 16'sh0003);
    ang = 13'd5191;
    for (int i = 0; i < 8; i++) begin
      ang = ang + 13'd500;
      send_frame(CMD_SAMPLE, ang, 16'sh7FFF, SPEED_W'($urandom));
    end
    for (int i = 0; i < 8; i++) begin
      ang = ang - 13'd700;
      send_frame(CMD_SAMPLE, ang, 16'sh8000, SPEED_W'($urandom));
    end
    rotor_pos = ang;
    drain();

    // Zero thresholds (every step wraps, standstill hits both), largest scale and gain
    program_regs(32'd0, 32'd0, 32'hFF_FFFF, 32'hFFFF_FFFF);
    run_motion(100);
    drain();

    // Widest thresholds, zero scale and gain
    program_regs(32'd8191, 32'd8191, 32'd0, 32'd0);
    run_motion(80);
    drain();

    // Back-to-back frames against a long receiver hold so the input backs up
    program_regs(32'd2500, 32'd2500, 32'd92160, 32'd1);
    tx_quiet = 1'b1;
    hold_len = HOLD_CYCLES;
    run_motion(120);
    drain();
    tx_quiet = 1'b0;

    // Random settings; one phase runs with no idling on either side
    for (int p = 0; p < 4; p++) begin
      program_regs($urandom_range(1500, 6000), $urandom_range(1500, 6000),
                   $urandom & 32'hFF_FFFF, $urandom);
      tx_quiet = (p == 2);
      rx_quiet = (p == 2);
      run_motion(100);
      drain();
    end
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;

    $display("checked %0d results from %0d frames (%0d zero captures) over %0d settings",
             sb.results, sb.frames, sb.captures, settings);
    $display("turn unwraps: %0d down, %0d up, %0d with both limits met; %0d long holds",
             sb.down_wraps, sb.up_wraps, sb.both_wraps, holds_done);
    if (sb.errors == 0 && sb.pending_q.size() == 0)
      $display("testbench OK");
    else
      $display("testbench NOT OK");
    $finish;
  end

endmodule
